@@ rtl/core/lbdc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbdc_pkg: shared types and constants
// Widths, status and opcode codes for the divisible binomial counter.
// ----------------------------------------------------------------------------
package lbdc_pkg;
   localparam int OPERAND_BITS = 48;
   localparam int BASE_BITS    = 8;
   localparam int DIFF_BITS    = 51;
   localparam int DIGIT_BITS   = 6;

   localparam logic [1:0] OP_COUNT    = 2'd0;
   localparam logic [1:0] OP_FIRST    = 2'd1;
   localparam logic [1:0] OP_SECOND   = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ILLEGAL  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef logic [OPERAND_BITS-1:0] operand_type;
   typedef logic [BASE_BITS-1:0]    base_type;

   typedef struct packed {
      logic [1:0]            opcode;
      operand_type           m_value;
      operand_type           count_limit;
      base_type              base;
      logic [DIGIT_BITS-1:0] first_digit;
      logic [DIGIT_BITS-1:0] second_digit;
   } req_type;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] difference;
      logic [1:0]                  status;
   } rsp_type;

   // divider unit control/status
   typedef struct packed {
      logic        start;
      operand_type dividend;
      base_type    divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      operand_type quotient;
      base_type    remainder;
   } div_rsp_type;
endpackage

@@ rtl/core/lbdc_if.sv @@
// ----------------------------------------------------------------------------
// lbdc_req_if / lbdc_rsp_if: valid/ready channels
// Request and response transfer interfaces.
// ----------------------------------------------------------------------------
interface lbdc_req_if;
   logic              valid;
   logic              ready;
   lbdc_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lbdc_rsp_if;
   logic              valid;
   logic              ready;
   lbdc_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/lucas_binomial_divisible_count_diff.sv @@
// ----------------------------------------------------------------------------
// lucas_binomial_divisible_count_diff: Lucas-theorem divisible count
// Counts k below n with a base-p digit above m's digit, with differences.
// ----------------------------------------------------------------------------
// Each H evaluation makes two passes of the shared divider per base-p digit,
// for the digits of m and n-1, plus a dispatch state (S_DM); a digit check
// at position e makes e+1 divider passes.
// Handshake: one item at a time, ready only in idle with no result held.
// Reset (synchronous, active high) returns to idle, no result pending.
module lucas_binomial_divisible_count_diff (
   input logic clock,
   input logic reset,
   lbdc_req_if.sink   req,
   lbdc_rsp_if.source rsp
);
   localparam int OB = lbdc_pkg::OPERAND_BITS;
   localparam int BB = lbdc_pkg::BASE_BITS;
   localparam int DB = lbdc_pkg::DIFF_BITS;
   localparam int PB = BB + OB; // product width before truncation

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;  // digit check: divide loop
   localparam logic [3:0] S_CHKW  = 4'd2;
   localparam logic [3:0] S_EVAL  = 4'd3;  // start eval of one H
   localparam logic [3:0] S_DM    = 4'd4;  // divide m digit
   localparam logic [3:0] S_DMW   = 4'd5;
   localparam logic [3:0] S_DYW   = 4'd7;  // wait for y digit
   localparam logic [3:0] S_ACC   = 4'd8;
   localparam logic [3:0] S_NEXT  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;
   localparam logic [3:0] S_PWR   = 4'd11; // power computation step

   logic [3:0] state_ff, state_in;
   lbdc_pkg::req_type rq_ff, rq_in;
   lbdc_pkg::rsp_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;

   // check phase: which increment (0 = r on m, 1 = s on m1)
   logic          chk_ff, chk_in;
   lbdc_pkg::operand_type pw_ff, pw_in;     // p^e
   logic [5:0]    pcnt_ff, pcnt_in;
   lbdc_pkg::operand_type m1_ff, m1_in, m12_ff, m12_in, m2_ff, m2_in;
   // eval phase
   logic [1:0]    ev_ff, ev_in;   // which H of up to four
   logic [1:0]    evn_ff, evn_in; // number of evaluations minus one
   lbdc_pkg::operand_type a_ff, a_in, b_ff, b_in;
   lbdc_pkg::base_type md_ff, md_in;
   // digits scanned from lsb: c is rebuilt as within count of low part
   lbdc_pkg::operand_type w_ff, w_in, c_ff, c_in;
   logic signed [DB-1:0] acc_ff, acc_in;

   lbdc_pkg::div_cmd_type dcmd;
   lbdc_pkg::div_rsp_type drsp;

   lbdc_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .rsp(drsp));

   logic [PB-1:0] prod;
   logic [PB-1:0] prod2;
   lbdc_pkg::operand_type cur_m, cur_base_m;
   logic [5:0] cur_e;
   lbdc_pkg::operand_type h_val;
   lbdc_pkg::base_type pm1;
   logic [OB:0] sum;

   assign pm1 = rq_ff.base - 1'b1;

   always_comb begin
      unique case (ev_ff)
         2'd0:    cur_m = rq_ff.m_value;
         2'd1:    cur_m = m1_ff;
         2'd2:    cur_m = m2_ff;
         default: cur_m = m12_ff;
      endcase
   end
   assign cur_base_m = chk_ff ? m1_ff : rq_ff.m_value;
   assign cur_e      = chk_ff ? rq_ff.second_digit : rq_ff.first_digit;
   assign prod  = PB'(pw_ff) * PB'(rq_ff.base);
   assign prod2 = PB'(w_ff)  * PB'({1'b0, md_ff} + 1'b1);
   // H = n - (within_count) ; within = c where c built lsb-first
   assign h_val = rq_ff.count_limit - c_ff;
   assign sum = {1'b0, cur_base_m} + {1'b0, pw_ff};

   always_comb begin
      state_in = state_ff;
      rq_in = rq_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      chk_in = chk_ff; pw_in = pw_ff; pcnt_in = pcnt_ff;
      m1_in = m1_ff; m12_in = m12_ff; m2_in = m2_ff;
      ev_in = ev_ff; evn_in = evn_ff;
      a_in = a_ff; b_in = b_ff; md_in = md_ff;
      w_in = w_ff; c_in = c_ff; acc_in = acc_ff;
      dcmd = '0;
      if (out_valid_ff && rsp.ready) out_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && !out_valid_ff) begin
               rq_in = req.payload;
               acc_in = '0;
               ev_in = 2'd0;
               chk_in = 1'b0;
               if (req.payload.base < BB'(2)) begin
                  out_in = '{difference: '0, status: lbdc_pkg::ST_OVERFLOW};
                  state_in = S_OUT;
               end else if (req.payload.opcode == lbdc_pkg::OP_COUNT) begin
                  evn_in = 2'd0;
                  state_in = S_EVAL;
               end else if (req.payload.opcode == lbdc_pkg::OP_FIRST) begin
                  evn_in = 2'd1;
                  pw_in = OB'(1); pcnt_in = '0;
                  state_in = S_PWR;
               end else if (req.payload.opcode == lbdc_pkg::OP_SECOND &&
                            req.payload.first_digit != req.payload.second_digit) begin
                  evn_in = 2'd3;
                  pw_in = OB'(1); pcnt_in = '0;
                  state_in = S_PWR;
               end else begin
                  out_in = '{difference: '0, status: lbdc_pkg::ST_ILLEGAL};
                  state_in = S_OUT;
               end
            end
         end
         S_PWR: begin
            if (pcnt_ff == cur_e) begin
               // digit = (m / pe) % p: divide m by p e times, then take the remainder of one more division
               a_in = cur_base_m; pcnt_in = '0;
               state_in = S_CHECK;
            end else if (prod[PB-1:OB] != '0) begin
               out_in = '{difference: '0, status: lbdc_pkg::ST_OVERFLOW};
               state_in = S_OUT;
            end else begin
               pw_in = prod[OB-1:0];
               pcnt_in = pcnt_ff + 1'b1;
            end
         end
         S_CHECK: begin
            dcmd.start = 1'b1;
            dcmd.dividend = a_ff;
            dcmd.divisor = rq_ff.base;
            state_in = S_CHKW;
         end
         S_CHKW: begin
            if (drsp.done) begin
               if (pcnt_ff == cur_e) begin
                  if (drsp.remainder == pm1) begin
                     out_in = '{difference: '0, status: lbdc_pkg::ST_ILLEGAL};
                     state_in = S_OUT;
                  end else if (sum[OB]) begin
                     out_in = '{difference: '0, status: lbdc_pkg::ST_OVERFLOW};
                     state_in = S_OUT;
                  end else if (!chk_ff) begin
                     m1_in = sum[OB-1:0];
                     if (evn_ff == 2'd1) begin
                        state_in = S_EVAL;
                     end else begin
                        chk_in = 1'b1; pw_in = OB'(1); pcnt_in = '0;
                        m2_in = rq_ff.m_value;
                        state_in = S_PWR;
                     end
                  end else begin
                     m12_in = sum[OB-1:0];
                     m2_in = rq_ff.m_value + pw_ff;
                     state_in = S_EVAL;
                  end
               end else begin
                  a_in = drsp.quotient;
                  pcnt_in = pcnt_ff + 1'b1;
                  state_in = S_CHECK;
               end
            end
         end
         S_EVAL: begin
            // within_count over y = n-1 built lsb-first: if y digit > m digit,
            // c = (md+1)*w (all lower combos); else c = yd*w + c.
            a_in = cur_m; b_in = rq_ff.count_limit - 1'b1;
            w_in = OB'(1); c_in = OB'(1);
            state_in = (rq_ff.count_limit == '0) ? S_NEXT : S_DM;
            if (rq_ff.count_limit == '0) c_in = '0;
         end
         S_DM: begin
            if ((a_ff | b_ff) == '0) begin
               state_in = S_NEXT;
            end else begin
               dcmd.start = 1'b1; dcmd.dividend = a_ff; dcmd.divisor = rq_ff.base;
               state_in = S_DMW;
            end
         end
         S_DMW: begin
            if (drsp.done) begin
               a_in = drsp.quotient; md_in = drsp.remainder;
               dcmd.start = 1'b1; dcmd.dividend = b_ff; dcmd.divisor = rq_ff.base;
               state_in = S_DYW;
            end
         end
         S_DYW: begin
            if (drsp.done) begin
               b_in = drsp.quotient;
               // yd > md: any allowed digit here is below yd, lower part free.
               // yd <= md: digits below yd leave the lower part free, digit
               // equal to yd keeps the bound on the lower part.
               if (drsp.remainder > md_ff)
                  c_in = prod2[OB-1:0];
               else
                  c_in = OB'(PB'(w_ff) * PB'(drsp.remainder) + PB'(c_ff));
               w_in = prod2[OB-1:0];
               state_in = S_DM;
            end
         end
         S_NEXT: begin
            if (ev_ff == 2'd0 || ev_ff == 2'd3)
               acc_in = acc_ff + DB'(h_val);
            else
               acc_in = acc_ff - DB'(h_val);
            if (ev_ff == evn_ff) begin
               state_in = S_ACC;
            end else begin
               ev_in = ev_ff + 1'b1;
               state_in = S_EVAL;
            end
         end
         S_ACC: begin
            if (rq_ff.opcode == lbdc_pkg::OP_FIRST)
               out_in = '{difference: -acc_ff, status: lbdc_pkg::ST_OK};
            else
               out_in = '{difference: acc_ff, status: lbdc_pkg::ST_OK};
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      rq_ff <= rq_in; out_ff <= out_in; chk_ff <= chk_in; pw_ff <= pw_in;
      pcnt_ff <= pcnt_in; m1_ff <= m1_in; m12_ff <= m12_in; m2_ff <= m2_in;
      ev_ff <= ev_in; evn_ff <= evn_in; a_ff <= a_in; b_ff <= b_in;
      md_ff <= md_in; w_ff <= w_in; c_ff <= c_in;
      acc_ff <= acc_in;
   end

   assign req.ready   = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   // a result is held until transferred
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("result dropped while stalled");
   // no new request while a result is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("ready while result pending");
   // nonzero status always carries a zero value
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.status != lbdc_pkg::ST_OK |->
      rsp.payload.difference == '0)
      else $error("status with nonzero value");
endmodule

@@ rtl/core/lbdc_divider.sv @@
// ----------------------------------------------------------------------------
// lbdc_divider: restoring radix-2 divider
// Divides an operand by the base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbdc_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  lbdc_pkg::div_cmd_type cmd,
   output lbdc_pkg::div_rsp_type rsp
);
   localparam int CNT_BITS = $clog2(lbdc_pkg::OPERAND_BITS + 1);

   logic                      busy_ff, busy_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   lbdc_pkg::operand_type     quo_ff, quo_in;
   logic [lbdc_pkg::BASE_BITS:0] rem_ff, rem_in;
   lbdc_pkg::base_type        dvs_ff, dvs_in;
   logic                      done_ff, done_in;
   logic [lbdc_pkg::BASE_BITS:0] trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      trial   = {rem_ff[lbdc_pkg::BASE_BITS-1:0], quo_ff[lbdc_pkg::OPERAND_BITS-1]};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(lbdc_pkg::OPERAND_BITS);
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[lbdc_pkg::OPERAND_BITS-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in    = trial - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff[lbdc_pkg::BASE_BITS-1:0];
endmodule
